// ===== rtl/rpwd_pkg.sv =====
// shared types, sizes and codes of the rc pulse width decoder
package rpwd_pkg;

    // frame and line counts
    localparam int MAX_SLOTS  = 8;
    localparam int PWM_LINES  = 5;
    localparam int SLOT_W     = $clog2(MAX_SLOTS + 1);
    localparam int LINE_IDX_W = (PWM_LINES > 1) ? $clog2(PWM_LINES) : 1;

    // field widths
    localparam int TS_W    = 32;
    localparam int GAP_W   = 20;
    localparam int LINE_W  = 3;
    localparam int CH_W    = 3;
    localparam int WIDTH_W = 16;
    localparam int MASK_W  = 8;

    // apb port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // register indexes
    localparam logic REG_PWM_MODE = 1'b0;
    localparam logic REG_SYNC_GAP = 1'b1;

    localparam logic [GAP_W-1:0] SYNC_GAP_RESET = GAP_W'(7500);

    typedef struct packed {
        logic              operation;
        logic [LINE_W-1:0] line;
        logic              level;
        logic [TS_W-1:0]   timestamp;
    } t_item;

    typedef struct packed {
        logic               captured;
        logic [CH_W-1:0]    channel;
        logic [WIDTH_W-1:0] width_ticks;
        logic [MASK_W-1:0]  good_mask;
    } t_result;

    typedef struct packed {
        logic             pwm_mode;
        logic [GAP_W-1:0] sync_gap_ticks;
    } t_cfg;

endpackage

// ===== rtl/rpwd_in_if.sv =====
// edge and poll item channel
interface rpwd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [rpwd_pkg::LINE_W-1:0]   line;
    logic                          level;
    logic [rpwd_pkg::TS_W-1:0]     timestamp;

    modport source (output valid, operation, line, level, timestamp, input ready);
    modport sink   (input valid, operation, line, level, timestamp, output ready);
endinterface

// ===== rtl/rpwd_out_if.sv =====
// decoded result item channel
interface rpwd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          captured;
    logic [rpwd_pkg::CH_W-1:0]     channel;
    logic [rpwd_pkg::WIDTH_W-1:0]  width_ticks;
    logic [rpwd_pkg::MASK_W-1:0]   good_mask;

    modport source (output valid, captured, channel, width_ticks, good_mask, input ready);
    modport sink   (input valid, captured, channel, width_ticks, good_mask, output ready);
endinterface

// ===== rtl/rpwd_cfg_regs.sv =====
// apb configuration registers of the decoder
module rpwd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpwd_pkg::APB_AW-1:0]   paddr,
    input  logic [rpwd_pkg::APB_DW-1:0]   pwdata,
    output logic [rpwd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output rpwd_pkg::t_cfg                o_cfg
);

    rpwd_pkg::t_cfg r_cfg;
    rpwd_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic           reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                rpwd_pkg::REG_PWM_MODE: n_cfg.pwm_mode       = pwdata[0];
                rpwd_pkg::REG_SYNC_GAP: n_cfg.sync_gap_ticks = pwdata[rpwd_pkg::GAP_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_mode       <= 1'b0;
            r_cfg.sync_gap_ticks <= rpwd_pkg::SYNC_GAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_sel)
            rpwd_pkg::REG_PWM_MODE: prdata = rpwd_pkg::APB_DW'(r_cfg.pwm_mode);
            rpwd_pkg::REG_SYNC_GAP: prdata = rpwd_pkg::APB_DW'(r_cfg.sync_gap_ticks);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/rpwd_core.sv =====
// decode state and per-item width computation
module rpwd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rpwd_pkg::t_item   i_item,
    input  rpwd_pkg::t_cfg    i_cfg,
    output rpwd_pkg::t_result o_result
);

    logic [rpwd_pkg::TS_W-1:0]    r_frame_start, n_frame_start;
    logic [rpwd_pkg::SLOT_W-1:0]  r_slot_idx, n_slot_idx;
    logic [rpwd_pkg::MASK_W-1:0]  r_slot_bit, n_slot_bit;
    logic [rpwd_pkg::MASK_W-1:0]  r_cap_bits, n_cap_bits;
    logic [rpwd_pkg::WIDTH_W-1:0] r_line_start [rpwd_pkg::PWM_LINES];

    logic [rpwd_pkg::TS_W-1:0]       frame_delta;
    logic [rpwd_pkg::WIDTH_W-1:0]    line_delta;
    logic [rpwd_pkg::LINE_IDX_W-1:0] line_idx;
    logic                            line_wr;
    rpwd_pkg::t_result               res;

    assign line_idx    = i_item.line[rpwd_pkg::LINE_IDX_W-1:0];
    assign frame_delta = i_item.timestamp - r_frame_start;
    assign line_delta  = i_item.timestamp[rpwd_pkg::WIDTH_W-1:0] - r_line_start[line_idx];

    always_comb begin
        n_frame_start   = r_frame_start;
        n_slot_idx      = r_slot_idx;
        n_slot_bit      = r_slot_bit;
        n_cap_bits      = r_cap_bits;
        line_wr         = 1'b0;
        res.captured    = 1'b0;
        res.channel     = '0;
        res.width_ticks = '0;

        if (i_item.operation == rpwd_pkg::OP_POLL) begin
            n_cap_bits = '0;
        end else if (!i_cfg.pwm_mode) begin
            // cppm: rising edges on line 0 only
            if (i_item.line == '0 && i_item.level) begin
                n_frame_start = i_item.timestamp;
                if (frame_delta > rpwd_pkg::TS_W'(i_cfg.sync_gap_ticks)) begin
                    n_slot_idx = '0;
                    n_slot_bit = rpwd_pkg::MASK_W'(1);
                end else if (r_slot_idx < rpwd_pkg::SLOT_W'(rpwd_pkg::MAX_SLOTS)) begin
                    n_cap_bits      = r_cap_bits | r_slot_bit;
                    n_slot_bit      = r_slot_bit << 1;
                    n_slot_idx      = r_slot_idx + 1'b1;
                    res.captured    = 1'b1;
                    res.channel     = rpwd_pkg::CH_W'(r_slot_idx);
                    res.width_ticks = frame_delta[rpwd_pkg::WIDTH_W-1:0];
                end
            end
        end else if ({1'b0, i_item.line} < (rpwd_pkg::LINE_W+1)'(rpwd_pkg::PWM_LINES)) begin
            if (i_item.line == '0) begin
                // line 0 keeps its full start time in the frame register
                if (i_item.level) begin
                    n_frame_start = i_item.timestamp;
                end else begin
                    n_cap_bits      = r_cap_bits | rpwd_pkg::MASK_W'(1);
                    res.captured    = 1'b1;
                    res.width_ticks = frame_delta[rpwd_pkg::WIDTH_W-1:0];
                end
            end else begin
                if (i_item.level) begin
                    line_wr = 1'b1;
                end else begin
                    n_cap_bits      = r_cap_bits | (rpwd_pkg::MASK_W'(1) << i_item.line);
                    res.captured    = 1'b1;
                    res.channel     = i_item.line;
                    res.width_ticks = line_delta;
                end
            end
        end

        // a poll reports the mask before clearing, an edge the mask after its own update
        res.good_mask = (i_item.operation == rpwd_pkg::OP_POLL) ? r_cap_bits : n_cap_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= '0;
            r_slot_idx    <= '0;
            r_slot_bit    <= '0;
            r_cap_bits    <= '0;
            for (int i = 0; i < rpwd_pkg::PWM_LINES; i++) begin
                r_line_start[i] <= '0;
            end
        end else if (i_fire) begin
            r_frame_start <= n_frame_start;
            r_slot_idx    <= n_slot_idx;
            r_slot_bit    <= n_slot_bit;
            r_cap_bits    <= n_cap_bits;
            if (line_wr) begin
                r_line_start[line_idx] <= i_item.timestamp[rpwd_pkg::WIDTH_W-1:0];
            end
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/rc_pulse_width_decoder.sv =====
// top level of the rc pulse width decoder: item registers, core and apb registers
//
// Decodes radio-control receiver pulses from timestamped pin edges. Each item is
// either an edge (line, level after the edge, 32-bit tick timestamp) or a poll.
// With pwm_mode = 0 (cppm) only rising edges on line 0 count: an interval above
// sync_gap_ticks restarts the frame at slot 0, one not above it is reported as the
// width of the next slot (up to 8 per frame) and sets that slot's good bit. With
// pwm_mode = 1 each of the five lines measures rising-to-falling width and sets
// its own good bit. Widths are the low 16 bits of the tick difference. A poll
// returns the good mask and clears it. Every item yields exactly one result item.
// Timing: an item is registered on entry, decoded from that register by a subtract
// and compare against the decode state, and lands in the result register; one item
// is taken every cycle as long as the result side keeps draining. pwm_mode lives at
// byte address 0 and sync_gap_ticks at byte address 4; write them only while no
// item is in flight.
module rc_pulse_width_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rpwd_in_if.sink                       i_item,
    rpwd_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpwd_pkg::APB_AW-1:0]   paddr,
    input  logic [rpwd_pkg::APB_DW-1:0]   pwdata,
    output logic [rpwd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    rpwd_pkg::t_cfg    cfg;
    rpwd_pkg::t_item   r_in_item;
    logic              r_in_valid;
    rpwd_pkg::t_result r_out;
    logic              r_out_valid;
    rpwd_pkg::t_result core_res;
    logic              in_take;
    logic              dec_fire;

    // config registers
    rpwd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // decode fires when the input register holds an item and the result slot is free
    assign dec_fire     = r_in_valid && (!r_out_valid || o_result.ready);
    // the input register refills in the same cycle it drains
    assign i_item.ready = !r_in_valid || dec_fire;
    assign in_take      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.operation <= i_item.operation;
            r_in_item.line      <= i_item.line;
            r_in_item.level     <= i_item.level;
            r_in_item.timestamp <= i_item.timestamp;
        end
    end

    // decode state and width math
    rpwd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (dec_fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // result register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.captured    = r_out.captured;
    assign o_result.channel     = r_out.channel;
    assign o_result.width_ticks = r_out.width_ticks;
    assign o_result.good_mask   = r_out.good_mask;

endmodule
